// ===== rtl/core/erf_pkg.sv =====
// ----------------------------------------------------------------------------
// erf_pkg
// Shared types, constants and helpers of the receive address filter.
// ----------------------------------------------------------------------------
package erf_pkg;

  localparam int TABLE_ENTRIES     = 64;
  localparam int HEADER_SKIP_BYTES = 10;

  localparam int MAC_W       = 48;
  localparam int BYTE_W      = 8;
  localparam int ENTRY_IDX_W = 6;
  localparam int CNT_REG_W   = 7;
  localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);

  localparam int DST_BYTES = 6;
  localparam int OFF_TYPE  = 12;
  localparam int OFF_TAG   = 14;
  localparam int OFF_LAST  = 15;
  localparam int POS_W     = $clog2(HEADER_SKIP_BYTES + OFF_LAST + 1);

  localparam int VLAN_WORDS = 128;
  localparam int VLAN_AW    = $clog2(VLAN_WORDS);
  localparam int VLAN_DW    = 32;
  localparam int VID_W      = 12;
  localparam int VBIT_W     = $clog2(VLAN_DW);

  localparam int MCAST_BIT = MAC_W - BYTE_W;

  localparam logic [15:0]      TPID_VLAN = 16'h8100;
  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // operation codes of an input item
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_VLAN  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VNET_HDR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNICAST_CNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CNT   = 3'd4;

  // filter_mode bits
  localparam int MODE_PROMISC   = 0;
  localparam int MODE_NO_BCAST  = 1;
  localparam int MODE_NO_MCAST  = 2;
  localparam int MODE_ALL_MCAST = 3;
  localparam int MODE_NO_UCAST  = 4;
  localparam int MODE_ALL_UCAST = 5;
  localparam int MODE_UCAST_OVF = 6;
  localparam int MODE_MCAST_OVF = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VLAN,
    ST_WALK,
    ST_OUT
  } state_t;

  // lookup token that walks the cell chain
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [MAC_W-1:0] dst;
  } query_t;

  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [MAC_W-1:0]       mac;
  } entry_wr_t;

  function automatic logic [CNT_W-1:0] clamp_entries(input logic [CNT_REG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (int'(v) > TABLE_ENTRIES) begin
      r = CNT_W'(TABLE_ENTRIES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/erf_ram.sv =====
// ----------------------------------------------------------------------------
// erf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module erf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/erf_cell.sv =====
// ----------------------------------------------------------------------------
// erf_cell
// One address table entry; compares the passing lookup token and hands it on.
// ----------------------------------------------------------------------------
module erf_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [erf_pkg::MAC_W-1:0] wr_mac,
  input  erf_pkg::query_t         q_in,
  output erf_pkg::query_t         q_out
);

  logic [erf_pkg::MAC_W-1:0] entry_r;
  logic                      vld_r;
  erf_pkg::query_t           q_r;
  erf_pkg::query_t           q_nxt;
  logic                      in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_mac;
    end
  end

  // the token carries the index of the cell it enters
  assign in_range = (q_in.idx >= q_in.lo) && (q_in.idx < q_in.hi);

  always_comb begin
    q_nxt     = q_in;
    q_nxt.hit = q_in.hit | (q_in.vld & in_range & (entry_r == q_in.dst));
    q_nxt.idx = q_in.idx + erf_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= q_in.vld;
    end
  end

  always_comb begin
    q_out     = q_r;
    q_out.vld = vld_r;
  end

endmodule

// ===== rtl/core/erf_chain.sv =====
// ----------------------------------------------------------------------------
// erf_chain
// Row of table cells; a lookup token enters cell 0 and leaves after the last.
// ----------------------------------------------------------------------------
module erf_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  erf_pkg::entry_wr_t wr,
  input  erf_pkg::query_t    q_in,
  output erf_pkg::query_t    q_out
);

  erf_pkg::query_t link [erf_pkg::TABLE_ENTRIES+1];

  assign link[0] = q_in;

  for (genvar i = 0; i < erf_pkg::TABLE_ENTRIES; i++) begin : g_cell
    logic wr_en;
    assign wr_en = wr.en && (int'(wr.idx) == i);

    erf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (wr_en),
      .wr_mac (wr.mac),
      .q_in   (link[i]),
      .q_out  (link[i+1])
    );
  end

  assign q_out = link[erf_pkg::TABLE_ENTRIES];

endmodule

// ===== rtl/core/ethernet_receive_address_filter.sv =====
// ----------------------------------------------------------------------------
// ethernet_receive_address_filter
// Receive filter: parses destination, type and tag of each frame and gives
// one accept/drop decision from mode flags, VLAN bitmap and address table.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | operation, frame byte/start, entry, vlan
//  out     | out_valid / out_ready  | accept
//  cfg     | cfg_we                 | cfg_index, cfg_wdata
//
// A frame byte, table write or bitmap write is taken only in the idle state.
// The byte that completes the header window starts the VLAN bitmap read and,
// when a table lookup is needed, a pass of the token through all TABLE_ENTRIES
// cells of the chain; in_ready stays low until the decision item is taken.
// Reset is synchronous and clears the bitmap valid bits at once.
// ----------------------------------------------------------------------------
module ethernet_receive_address_filter (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic [7:0]                        in_frame_byte,
  input  logic                              in_frame_start,
  input  logic [5:0]                        in_entry_index,
  input  logic [47:0]                       in_entry_mac,
  input  logic [6:0]                        in_vlan_word_index,
  input  logic [31:0]                       in_vlan_word,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accept,

  input  logic                              cfg_we,
  input  logic [erf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [47:0]                       cfg_wdata
);

  // configuration
  logic [7:0]                      mode_r;
  logic                            vnet_r;
  logic [erf_pkg::MAC_W-1:0]       own_mac_r;
  logic [erf_pkg::CNT_REG_W-1:0]   ucnt_r;
  logic [erf_pkg::CNT_REG_W-1:0]   tcnt_r;

  // frame capture
  logic [erf_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                            done_r, done_nxt;
  logic [erf_pkg::MAC_W-1:0]       dst_r, dst_nxt;
  logic [15:0]                     type_r, type_nxt;
  logic [15:0]                     tag_r, tag_nxt;
  logic [erf_pkg::POS_W-1:0]       off;
  logic                            last;

  // control
  erf_pkg::state_t                 state_r, state_nxt;
  logic                            acc_r, acc_nxt;
  logic                            in_acc;
  logic                            launch;

  // VLAN bitmap
  logic [erf_pkg::VLAN_WORDS-1:0]  vbits_r;
  logic                            wvld_r;
  logic [erf_pkg::VBIT_W-1:0]      vbit_r;
  logic [erf_pkg::VLAN_DW-1:0]     vword;
  logic [erf_pkg::VID_W-1:0]       vid;
  logic                            vlan_we;
  logic                            vlan_ok;

  // decision
  logic                            fin_acc;
  logic                            walk;
  logic [erf_pkg::CNT_W-1:0]       lo;
  logic [erf_pkg::CNT_W-1:0]       hi;
  erf_pkg::query_t                 q_launch;
  erf_pkg::query_t                 q_done;
  erf_pkg::entry_wr_t              ent_wr;

  assign in_acc = in_valid && in_ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      vnet_r    <= 1'b0;
      own_mac_r <= '0;
      ucnt_r    <= '0;
      tcnt_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        erf_pkg::CFG_FILTER_MODE: mode_r    <= cfg_wdata[7:0];
        erf_pkg::CFG_VNET_HDR:    vnet_r    <= cfg_wdata[0];
        erf_pkg::CFG_OWN_MAC:     own_mac_r <= cfg_wdata;
        erf_pkg::CFG_UNICAST_CNT: ucnt_r    <= cfg_wdata[erf_pkg::CNT_REG_W-1:0];
        erf_pkg::CFG_TOTAL_CNT:   tcnt_r    <= cfg_wdata[erf_pkg::CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- frame capture
  always_comb begin
    pos_nxt  = pos_r;
    done_nxt = done_r;
    dst_nxt  = dst_r;
    type_nxt = type_r;
    tag_nxt  = tag_r;
    off      = '0;
    last     = 1'b0;
    if (in_acc && in_operation == erf_pkg::OP_BYTE) begin
      if (in_frame_start) begin
        pos_nxt  = '0;
        done_nxt = 1'b0;
        dst_nxt  = '0;
        type_nxt = '0;
        tag_nxt  = '0;
      end
      if (!done_nxt) begin
        if (vnet_r && pos_nxt < erf_pkg::POS_W'(erf_pkg::HEADER_SKIP_BYTES)) begin
          pos_nxt = pos_nxt + erf_pkg::POS_W'(1);
        end else begin
          off = vnet_r ? pos_nxt - erf_pkg::POS_W'(erf_pkg::HEADER_SKIP_BYTES) : pos_nxt;
          pos_nxt = pos_nxt + erf_pkg::POS_W'(1);
          if (off < erf_pkg::POS_W'(erf_pkg::DST_BYTES)) begin
            dst_nxt = {dst_nxt[erf_pkg::MAC_W-erf_pkg::BYTE_W-1:0], in_frame_byte};
          end else if (off == erf_pkg::POS_W'(erf_pkg::OFF_TYPE) ||
                       off == erf_pkg::POS_W'(erf_pkg::OFF_TYPE + 1)) begin
            type_nxt = {type_nxt[7:0], in_frame_byte};
          end else if (off == erf_pkg::POS_W'(erf_pkg::OFF_TAG) ||
                       off == erf_pkg::POS_W'(erf_pkg::OFF_TAG + 1)) begin
            tag_nxt = {tag_nxt[7:0], in_frame_byte};
          end
          if (off >= erf_pkg::POS_W'(erf_pkg::OFF_LAST)) begin
            done_nxt = 1'b1;
            last     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      done_r <= 1'b1;
      dst_r  <= '0;
      type_r <= '0;
      tag_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
      dst_r  <= dst_nxt;
      type_r <= type_nxt;
      tag_r  <= tag_nxt;
    end
  end

  // ----------------------------------------------------------- VLAN bitmap
  assign vlan_we = in_acc && in_operation == erf_pkg::OP_VLAN;
  assign vid     = tag_nxt[erf_pkg::VID_W-1:0];

  erf_ram #(
    .WIDTH (erf_pkg::VLAN_DW),
    .DEPTH (erf_pkg::VLAN_WORDS)
  ) u_vlan_ram (
    .clk   (clk),
    .we    (vlan_we),
    .waddr (in_vlan_word_index),
    .wdata (in_vlan_word),
    .re    (last),
    .raddr (vid[erf_pkg::VID_W-1:erf_pkg::VBIT_W]),
    .rdata (vword)
  );

  // a word never written reads as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= '0;
    end else if (vlan_we) begin
      vbits_r[in_vlan_word_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      wvld_r <= vbits_r[vid[erf_pkg::VID_W-1:erf_pkg::VBIT_W]];
      vbit_r <= vid[erf_pkg::VBIT_W-1:0];
    end
  end

  assign vlan_ok = wvld_r && vword[vbit_r];

  // -------------------------------------------------------------- decision
  always_comb begin
    fin_acc = 1'b0;
    walk    = 1'b0;
    lo      = '0;
    hi      = '0;
    if (mode_r[erf_pkg::MODE_PROMISC]) begin
      fin_acc = 1'b1;
    end else if (type_r == erf_pkg::TPID_VLAN && !vlan_ok) begin
      fin_acc = 1'b0;
    end else if (dst_r[erf_pkg::MCAST_BIT]) begin
      if (dst_r == erf_pkg::MAC_BCAST) begin
        fin_acc = !mode_r[erf_pkg::MODE_NO_BCAST];
      end else if (mode_r[erf_pkg::MODE_NO_MCAST]) begin
        fin_acc = 1'b0;
      end else if (mode_r[erf_pkg::MODE_ALL_MCAST] || mode_r[erf_pkg::MODE_MCAST_OVF]) begin
        fin_acc = 1'b1;
      end else begin
        walk = 1'b1;
        lo   = erf_pkg::clamp_entries(ucnt_r);
        hi   = erf_pkg::clamp_entries(tcnt_r);
      end
    end else if (mode_r[erf_pkg::MODE_NO_UCAST]) begin
      fin_acc = 1'b0;
    end else if (mode_r[erf_pkg::MODE_ALL_UCAST] || mode_r[erf_pkg::MODE_UCAST_OVF]) begin
      fin_acc = 1'b1;
    end else if (dst_r == own_mac_r) begin
      fin_acc = 1'b1;
    end else begin
      walk = 1'b1;
      hi   = erf_pkg::clamp_entries(ucnt_r);
    end
  end

  // ------------------------------------------------------------ cell chain
  always_comb begin
    ent_wr.en  = in_acc && in_operation == erf_pkg::OP_ENTRY;
    ent_wr.idx = in_entry_index;
    ent_wr.mac = in_entry_mac;
  end

  always_comb begin
    q_launch.vld = launch;
    q_launch.hit = 1'b0;
    q_launch.idx = '0;
    q_launch.lo  = lo;
    q_launch.hi  = hi;
    q_launch.dst = dst_r;
  end

  erf_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ent_wr),
    .q_in  (q_launch),
    .q_out (q_done)
  );

  // --------------------------------------------------------- state machine
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    case (state_r)
      erf_pkg::ST_IDLE: begin
        if (last) begin
          state_nxt = erf_pkg::ST_VLAN;
        end
      end
      erf_pkg::ST_VLAN: begin
        if (walk) begin
          state_nxt = erf_pkg::ST_WALK;
        end else begin
          state_nxt = erf_pkg::ST_OUT;
          acc_nxt   = fin_acc;
        end
      end
      erf_pkg::ST_WALK: begin
        if (q_done.vld) begin
          state_nxt = erf_pkg::ST_OUT;
          acc_nxt   = q_done.hit;
        end
      end
      erf_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = erf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = erf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    launch    = 1'b0;
    case (state_r)
      erf_pkg::ST_IDLE: in_ready  = 1'b1;
      erf_pkg::ST_VLAN: launch    = walk;
      erf_pkg::ST_WALK: ;
      erf_pkg::ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= erf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign out_accept = acc_r;

`ifndef ASSERT_OFF
  a_token_only_in_walk : assert property (@(posedge clk) disable iff (!rst_n)
    q_done.vld |-> state_r == erf_pkg::ST_WALK)
    else $error("lookup token left the chain outside the walk");

  a_vlan_after_byte : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == erf_pkg::ST_VLAN) |->
      $past(in_valid && in_ready && in_operation == erf_pkg::OP_BYTE))
    else $error("decision started without a frame byte");

  a_result_from_decision : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      ($past(state_r) == erf_pkg::ST_VLAN || $past(state_r) == erf_pkg::ST_WALK))
    else $error("result item raised without a decision");
`endif

endmodule
